@@ rtl/core/sssc_pkg.sv @@
// Shared types and constants for the ascending sorter core.
`default_nettype none
package sssc_pkg;

   localparam int SET_CAPACITY = 8;
   localparam int KEY_W        = 8;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place req key into the ordered chain
      logic shift;    // move every entry one cell towards the head
   } cell_ctrl_type;

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/small_set_ascending_sorter_core.sv @@
// Top level of the ascending sorter: a chain of insertion cells plus drain control.
// Loading: one key per cycle, each transaction placed in order in the same cycle.
// Draining: after the end-marked key, one result per cycle from the head cell while
//   rsp_ready is high, for a set of n keys (n up to SET_CAPACITY).
// Input is not accepted while a set is draining; the next set starts the cycle after.
// Synchronous active-high reset empties the chain and clears the overflow flag.
`default_nettype none
module small_set_ascending_sorter_core
   import sssc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic             req_end_of_set,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [KEY_W-1:0] rsp_sorted_key,
   output logic                  rsp_final_key,
   output logic                  rsp_overflowed
);

   logic                    state_ff, state_in;
   logic                    overflow_ff, overflow_in;
   logic [KEY_W-1:0]        cell_key   [SET_CAPACITY];
   logic [SET_CAPACITY-1:0] cell_valid;
   logic [SET_CAPACITY-1:0] cell_place;
   cell_ctrl_type           ctrl;
   logic                    req_take;
   logic                    rsp_take;
   logic                    full;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign full      = cell_valid[SET_CAPACITY-1];

   assign rsp_valid      = (state_ff == ST_DRAIN) && cell_valid[0];
   assign rsp_sorted_key = cell_key[0];
   assign rsp_final_key  = !cell_valid[1];
   assign rsp_overflowed = overflow_ff;
   assign rsp_take       = rsp_valid && rsp_ready;

   assign ctrl.insert = req_take && !full;
   assign ctrl.shift  = rsp_take;

   genvar gi;
   generate
      for (gi = 0; gi < SET_CAPACITY; gi++) begin : g_cell
         logic [KEY_W-1:0] prev_key, next_key;
         logic             prev_valid, prev_place, next_valid;
         if (gi == 0) begin : g_head
            assign prev_key   = req_key;
            assign prev_valid = 1'b1;
            assign prev_place = 1'b0;
         end else begin : g_body
            assign prev_key   = cell_key[gi-1];
            assign prev_valid = cell_valid[gi-1];
            assign prev_place = cell_place[gi-1];
         end
         if (gi == SET_CAPACITY-1) begin : g_tail
            assign next_key   = cell_key[gi];
            assign next_valid = 1'b0;
         end else begin : g_mid
            assign next_key   = cell_key[gi+1];
            assign next_valid = cell_valid[gi+1];
         end
         sssc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_key    (req_key),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .prev_place (prev_place),
            .next_key   (next_key),
            .next_valid (next_valid),
            .key        (cell_key[gi]),
            .valid      (cell_valid[gi]),
            .place      (cell_place[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && full) begin
               overflow_in = 1'b1;
            end
            if (req_take && req_end_of_set) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_take && rsp_final_key) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // Occupied cells always form an unbroken run from the head
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + SET_CAPACITY'(1)) & cell_valid) == '0)
      else $error("chain holds a gap");

   a_end_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_set) |=> rsp_valid)
      else $error("set end did not start output");

   a_final_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_final_key) |=> (!rsp_valid && req_ready && cell_valid == '0))
      else $error("chain not empty after final result");

   a_no_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while draining");

endmodule
`default_nettype wire

@@ rtl/core/sssc_cell.sv @@
// One cell of the insertion chain: holds a key and its valid bit.
`default_nettype none
module sssc_cell
   import sssc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic [KEY_W-1:0] new_key,
   input  wire logic [KEY_W-1:0] prev_key,
   input  wire logic             prev_valid,
   input  wire logic             prev_place,
   input  wire logic [KEY_W-1:0] next_key,
   input  wire logic             next_valid,
   output logic      [KEY_W-1:0] key,
   output logic                  valid,
   output logic                  place
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] ins_key;

   // Incoming key is smaller than ours: we move one cell along
   assign place = valid_ff && (new_key < key_ff);
   assign ins_key = prev_place ? prev_key : new_key;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         key_in   = next_key;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         if (place) begin
            key_in = ins_key;
         end else if (!valid_ff && prev_valid) begin
            // first empty cell takes the key or the one pushed from the previous cell
            key_in   = ins_key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire
